@@ sv/rsi_pkg.sv @@
// Shared types, widths and helper functions for the ray/sphere intersection block.
// Used by the iteration cells, the multiplier and the top level; depends on nothing.
package rsi_pkg;

    localparam int FRAC_BITS = 16;
    localparam int COORD_W   = 32;
    localparam int RAD_W     = COORD_W - 1;
    localparam int WIDE_W    = 2 * COORD_W;

    localparam int DD_W   = 2 * COORD_W;
    localparam int DXO_W  = 2 * COORD_W + 1;
    localparam int OO_W   = 2 * COORD_W + 2;
    localparam int RSQ_W  = 2 * RAD_W;
    localparam int ACC_W  = 2 * COORD_W + 2;
    localparam int BS_W   = 2 * COORD_W + 3;
    localparam int SQ_W   = 2 * COORD_W + 4;

    localparam int A_W    = 2 * COORD_W - FRAC_BITS;
    localparam int B_W    = A_W + 1;
    localparam int C_W    = A_W + 2;
    localparam int DIS_W  = 2 * C_W;
    localparam int S_W    = C_W;
    localparam int SUM_W  = S_W + 1;
    localparam int T_W    = 62;
    localparam int P_W    = A_W + T_W;
    localparam int NUM1_W = SUM_W + FRAC_BITS;
    localparam int NUM2_W = C_W + 2 * FRAC_BITS;
    localparam int NUMN_W = COORD_W + 1 + FRAC_BITS;

    localparam int DIV_NUM_W = NUM2_W;
    localparam int DIV_DEN_W = P_W;

    localparam int MUL_W  = 64;
    localparam int PROD_W = 2 * MUL_W;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Z = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS   = 2'd3;

    localparam logic [RAD_W-1:0] RAD_RESET = RAD_W'(1) << FRAC_BITS;

    localparam logic signed [WIDE_W-1:0] COORD_MAX =
        (WIDE_W'(64'sd1) <<< (COORD_W - 1)) - WIDE_W'(64'sd1);
    localparam logic signed [WIDE_W-1:0] COORD_MIN = -COORD_MAX - WIDE_W'(64'sd1);

    typedef struct packed {
        logic [DIS_W-1:0] rad;
        logic [S_W:0]     rem;
        logic [S_W-1:0]   root;
    } sqrt_t;

    typedef struct packed {
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] rem;
        logic [DIV_NUM_W-1:0] quo;
        logic [DIV_DEN_W-1:0] den;
    } div_t;

    function automatic logic [T_W-1:0] cap_mag(input logic [PROD_W-1:0] v);
        if (|v[PROD_W-1:T_W]) begin
            return '1;
        end
        return v[T_W-1:0];
    endfunction

    function automatic logic [COORD_W-1:0] sat_coord(input logic signed [WIDE_W-1:0] v);
        if (v > COORD_MAX) begin
            return COORD_MAX[COORD_W-1:0];
        end
        if (v < COORD_MIN) begin
            return COORD_MIN[COORD_W-1:0];
        end
        return v[COORD_W-1:0];
    endfunction

endpackage

@@ sv/ray_sphere_intersect.sv @@
// Top level of the ray/sphere intersection block: setup stages, square root and divider chains.
// Depends on rsi_pkg, rsi_mul, rsi_sqrt_cell and rsi_div_cell.
//
// The block takes one ray request in every clock cycle; busy is always low. Each request
// flows through the pipeline and its result appears on the output ports, marked by done.
// The pipeline is built from the bit-serial chains: a 50-cell square root, a 67-cell and
// an 82-cell divider for the two roots, and three parallel 49-cell dividers for the
// normal, plus 18 setup and multiplier stages.
// Results come out in request order, one per request, and cannot be held off, so the
// receiver must take done and its fields in the cycle they appear. The sphere center and
// radius must only be written while no request is in flight.
module ray_sphere_intersect
    import rsi_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic signed [COORD_W-1:0] origin_x,
    input  logic signed [COORD_W-1:0] origin_y,
    input  logic signed [COORD_W-1:0] origin_z,
    input  logic signed [COORD_W-1:0] dir_x,
    input  logic signed [COORD_W-1:0] dir_y,
    input  logic signed [COORD_W-1:0] dir_z,
    input  logic signed [COORD_W-1:0] t_min,
    input  logic signed [COORD_W-1:0] t_max,
    input  logic                      cfg_we,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [COORD_W-1:0]        cfg_wdata,
    output logic                      done,
    output logic                      is_hit,
    output logic signed [COORD_W-1:0] hit_t,
    output logic signed [COORD_W-1:0] point_x,
    output logic signed [COORD_W-1:0] point_y,
    output logic signed [COORD_W-1:0] point_z,
    output logic signed [COORD_W-1:0] normal_x,
    output logic signed [COORD_W-1:0] normal_y,
    output logic signed [COORD_W-1:0] normal_z
);

    typedef struct packed {
        logic [2:0][COORD_W-1:0] o;
        logic [2:0]              dneg;
        logic [2:0][COORD_W-1:0] dmag;
        logic [COORD_W-1:0]      tlo;
        logic [COORD_W-1:0]      thi;
        logic [A_W-1:0]          a;
        logic [B_W-1:0]          bmag;
        logic                    bneg;
        logic [C_W-1:0]          cmag;
        logic                    cneg;
        logic                    miss;
        logic [T_W-1:0]          tmag;
        logic                    tneg;
        logic                    hit1;
        logic [2:0][COORD_W-1:0] pt;
        logic [2:0]              nneg;
    } ray_t;

    function automatic logic in_range(input logic tn, input logic [T_W-1:0] tm,
                                      input logic [COORD_W-1:0] lo,
                                      input logic [COORD_W-1:0] hi);
        logic signed [WIDE_W-1:0] tv;
        logic signed [WIDE_W-1:0] lo_w;
        logic signed [WIDE_W-1:0] hi_w;
        tv   = tn ? -$signed(WIDE_W'(tm)) : $signed(WIDE_W'(tm));
        lo_w = WIDE_W'($signed(lo));
        hi_w = WIDE_W'($signed(hi));
        return (lo_w < tv) && (tv < hi_w);
    endfunction

    assign busy = 1'b0;

    // Configuration registers.
    logic [2:0][COORD_W-1:0] ctr_reg;
    logic [RAD_W-1:0]        rad_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            ctr_reg <= '0;
            rad_reg <= RAD_RESET;
        end
        else if (cfg_we) begin
            case (cfg_index)
                CFG_CENTER_X: ctr_reg[0] <= cfg_wdata;
                CFG_CENTER_Y: ctr_reg[1] <= cfg_wdata;
                CFG_CENTER_Z: ctr_reg[2] <= cfg_wdata;
                CFG_RADIUS:   rad_reg    <= cfg_wdata[RAD_W-1:0];
                default: ;
            endcase
        end
    end

    // Request capture and origin relative to the center.
    logic [2:0][COORD_W-1:0] o_in, d_in;
    logic [2:0][COORD_W-1:0] o0_reg, d0_reg;
    logic [2:0][COORD_W:0]   oc0_reg;
    logic [COORD_W-1:0]      tlo0_reg, thi0_reg;
    logic                    v0_reg;

    assign o_in = {origin_z, origin_y, origin_x};
    assign d_in = {dir_z, dir_y, dir_x};

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++) begin
            o0_reg[i]  <= o_in[i];
            d0_reg[i]  <= d_in[i];
            oc0_reg[i] <= (COORD_W+1)'($signed(o_in[i])) - (COORD_W+1)'($signed(ctr_reg[i]));
        end
        tlo0_reg <= t_min;
        thi0_reg <= t_max;
    end

    // Products of the direction and the relative origin.
    logic [2:0]              dn0, on0;
    logic [2:0][COORD_W-1:0] dm0;
    logic [2:0][COORD_W:0]   om0;
    ray_t                    r1_next, r1_reg;
    logic [2:0][DD_W-1:0]    dd1_reg;
    logic [2:0][DXO_W-1:0]   dxo1_reg;
    logic [2:0][OO_W-1:0]    oo1_reg;
    logic [2:0]              dxn1_reg;
    logic [RSQ_W-1:0]        rsq1_reg;
    logic                    v1_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++) begin
            dn0[i] = d0_reg[i][COORD_W-1];
            dm0[i] = dn0[i] ? -d0_reg[i] : d0_reg[i];
            on0[i] = oc0_reg[i][COORD_W];
            om0[i] = on0[i] ? -oc0_reg[i] : oc0_reg[i];
        end
        r1_next      = '0;
        r1_next.o    = o0_reg;
        r1_next.dneg = dn0;
        r1_next.dmag = dm0;
        r1_next.tlo  = tlo0_reg;
        r1_next.thi  = thi0_reg;
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++) begin
            dd1_reg[i]  <= DD_W'(dm0[i]) * DD_W'(dm0[i]);
            dxo1_reg[i] <= DXO_W'(dm0[i]) * DXO_W'(om0[i]);
            oo1_reg[i]  <= OO_W'(om0[i]) * OO_W'(om0[i]);
            dxn1_reg[i] <= dn0[i] ^ on0[i];
        end
        rsq1_reg <= RSQ_W'(rad_reg) * RSQ_W'(rad_reg);
        r1_reg   <= r1_next;
    end

    // Sums of the three components.
    logic [ACC_W-1:0] acc2_next, acc2_reg;
    logic [BS_W-1:0]  pos2_next, neg2_next, pos2_reg, neg2_reg;
    logic [SQ_W-1:0]  sq2_next, sq2_reg;
    logic [RSQ_W-1:0] rsq2_reg;
    ray_t             r2_reg;
    logic             v2_reg;

    always_comb
    begin
        acc2_next = '0;
        pos2_next = '0;
        neg2_next = '0;
        sq2_next  = '0;
        for (int i = 0; i < 3; i++) begin
            acc2_next = acc2_next + ACC_W'(dd1_reg[i]);
            sq2_next  = sq2_next + SQ_W'(oo1_reg[i]);
            if (dxn1_reg[i]) begin
                neg2_next = neg2_next + BS_W'(dxo1_reg[i]);
            end
            else begin
                pos2_next = pos2_next + BS_W'(dxo1_reg[i]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        acc2_reg <= acc2_next;
        pos2_reg <= pos2_next;
        neg2_reg <= neg2_next;
        sq2_reg  <= sq2_next;
        rsq2_reg <= rsq1_reg;
        r2_reg   <= r1_reg;
    end

    // Quadratic coefficients in sign and magnitude form.
    logic [BS_W-1:0] bdiff;
    logic [SQ_W-1:0] cdiff;
    logic [SQ_W-1:0] rsq_w;
    ray_t            r3_next, r3_reg;
    logic            v3_reg;

    always_comb
    begin
        r3_next      = r2_reg;
        r3_next.a    = acc2_reg[A_W+FRAC_BITS-1:FRAC_BITS];
        r3_next.bneg = (neg2_reg > pos2_reg);
        bdiff        = r3_next.bneg ? (neg2_reg - pos2_reg) : (pos2_reg - neg2_reg);
        r3_next.bmag = bdiff[B_W+FRAC_BITS-1:FRAC_BITS];
        if (r3_next.bmag == '0) begin
            r3_next.bneg = 1'b0;
        end
        rsq_w        = SQ_W'(rsq2_reg);
        r3_next.cneg = (rsq_w > sq2_reg);
        cdiff        = r3_next.cneg ? (rsq_w - sq2_reg) : (sq2_reg - rsq_w);
        r3_next.cmag = cdiff[C_W+FRAC_BITS-1:FRAC_BITS];
        if (r3_next.cmag == '0) begin
            r3_next.cneg = 1'b0;
        end
        r3_next.miss = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        r3_reg <= r3_next;
    end

    // Discriminant products.
    logic [PROD_W-1:0] bb_prod, ac_prod;
    ray_t              m1_reg [2];
    logic [1:0]        m1v_reg;

    rsi_mul u_mul_bb (
        .clk  (clk),
        .x    (MUL_W'(r3_reg.bmag)),
        .y    (MUL_W'(r3_reg.bmag)),
        .prod (bb_prod)
    );

    rsi_mul u_mul_ac (
        .clk  (clk),
        .x    (MUL_W'(r3_reg.a)),
        .y    (MUL_W'(r3_reg.cmag)),
        .prod (ac_prod)
    );

    always_ff @(posedge clk)
    begin
        m1_reg[0] <= r3_reg;
        m1_reg[1] <= m1_reg[0];
    end

    // Discriminant and square root chain.
    logic [DIS_W-1:0] bb_w, ac_w;
    sqrt_t            sq_in_next, sq_in_reg;
    ray_t             r6_next, r6_reg;
    logic             v6_reg;
    sqrt_t            sqw [S_W+1];
    ray_t             sqs_reg [S_W];
    logic [S_W-1:0]   sqv_reg;

    always_comb
    begin
        bb_w       = bb_prod[DIS_W-1:0];
        ac_w       = ac_prod[DIS_W-1:0];
        r6_next    = m1_reg[1];
        sq_in_next = '0;
        if (r6_next.cneg) begin
            sq_in_next.rad = bb_w + ac_w;
        end
        else if (ac_w > bb_w) begin
            r6_next.miss = 1'b1;
        end
        else begin
            sq_in_next.rad = bb_w - ac_w;
        end
    end

    always_ff @(posedge clk)
    begin
        sq_in_reg <= sq_in_next;
        r6_reg    <= r6_next;
    end

    assign sqw[0] = sq_in_reg;

    for (genvar k = 0; k < S_W; k++) begin : g_sqrt
        rsi_sqrt_cell u_cell (
            .clk   (clk),
            .d_in  (sqw[k]),
            .d_out (sqw[k+1])
        );
    end

    always_ff @(posedge clk)
    begin
        sqs_reg[0] <= r6_reg;
        for (int k = 1; k < S_W; k++) begin
            sqs_reg[k] <= sqs_reg[k-1];
        end
    end

    // Nearer root: setup and divider chain.
    logic [SUM_W-1:0]  bs_sum;
    logic [NUM1_W-1:0] num1;
    div_t              d1_in_next, d1_in_reg;
    ray_t              r7_next, r7_reg;
    logic              v7_reg;
    div_t              d1w [NUM1_W+1];
    ray_t              d1s_reg [NUM1_W];
    logic [NUM1_W-1:0] d1v_reg;

    always_comb
    begin
        r7_next    = sqs_reg[S_W-1];
        bs_sum     = SUM_W'(r7_next.bmag) + SUM_W'(sqw[S_W].root);
        d1_in_next = '0;
        if (!r7_next.bneg && (r7_next.bmag != '0)) begin
            if (r7_next.a == '0) begin
                r7_next.miss = 1'b1;
            end
            num1           = NUM1_W'(bs_sum) << FRAC_BITS;
            d1_in_next.den = DIV_DEN_W'(r7_next.a);
            r7_next.tneg   = 1'b1;
        end
        else begin
            if (bs_sum == '0) begin
                r7_next.miss = 1'b1;
            end
            num1           = NUM1_W'(r7_next.cmag) << FRAC_BITS;
            d1_in_next.den = DIV_DEN_W'(bs_sum);
            r7_next.tneg   = r7_next.cneg;
        end
        d1_in_next.num = DIV_NUM_W'(num1) << (DIV_NUM_W - NUM1_W);
    end

    always_ff @(posedge clk)
    begin
        d1_in_reg <= d1_in_next;
        r7_reg    <= r7_next;
    end

    assign d1w[0] = d1_in_reg;

    for (genvar k = 0; k < NUM1_W; k++) begin : g_div1
        rsi_div_cell u_cell (
            .clk   (clk),
            .d_in  (d1w[k]),
            .d_out (d1w[k+1])
        );
    end

    always_ff @(posedge clk)
    begin
        d1s_reg[0] <= r7_reg;
        for (int k = 1; k < NUM1_W; k++) begin
            d1s_reg[k] <= d1s_reg[k-1];
        end
    end

    // Nearer root range check.
    ray_t r8_next, r8_reg;
    logic v8_reg;

    always_comb
    begin
        r8_next      = d1s_reg[NUM1_W-1];
        r8_next.tmag = cap_mag(PROD_W'(d1w[NUM1_W].quo[NUM1_W-1:0]));
        r8_next.hit1 = in_range(r8_next.tneg, r8_next.tmag, r8_next.tlo, r8_next.thi);
    end

    always_ff @(posedge clk)
    begin
        r8_reg <= r8_next;
    end

    // Farther root: a*t product, setup and divider chain.
    logic [PROD_W-1:0] p_prod;
    ray_t              m2_reg [2];
    logic [1:0]        m2v_reg;
    logic [P_W-1:0]    p_w;
    div_t              d2_in_next, d2_in_reg;
    ray_t              r11_next, r11_reg;
    logic              v11_reg;
    div_t              d2w [NUM2_W+1];
    ray_t              d2s_reg [NUM2_W];
    logic [NUM2_W-1:0] d2v_reg;

    rsi_mul u_mul_p (
        .clk  (clk),
        .x    (MUL_W'(r8_reg.a)),
        .y    (MUL_W'(r8_reg.tmag)),
        .prod (p_prod)
    );

    always_ff @(posedge clk)
    begin
        m2_reg[0] <= r8_reg;
        m2_reg[1] <= m2_reg[0];
    end

    always_comb
    begin
        r11_next = m2_reg[1];
        p_w      = p_prod[P_W-1:0];
        if (!r11_next.hit1 && (p_w == '0)) begin
            r11_next.miss = 1'b1;
        end
        d2_in_next     = '0;
        d2_in_next.num = DIV_NUM_W'(NUM2_W'(r11_next.cmag) << (2 * FRAC_BITS))
                         << (DIV_NUM_W - NUM2_W);
        d2_in_next.den = DIV_DEN_W'(p_w);
    end

    always_ff @(posedge clk)
    begin
        d2_in_reg <= d2_in_next;
        r11_reg   <= r11_next;
    end

    assign d2w[0] = d2_in_reg;

    for (genvar k = 0; k < NUM2_W; k++) begin : g_div2
        rsi_div_cell u_cell (
            .clk   (clk),
            .d_in  (d2w[k]),
            .d_out (d2w[k+1])
        );
    end

    always_ff @(posedge clk)
    begin
        d2s_reg[0] <= r11_reg;
        for (int k = 1; k < NUM2_W; k++) begin
            d2s_reg[k] <= d2s_reg[k-1];
        end
    end

    // Root selection.
    logic [T_W-1:0] tm2;
    logic           tn2;
    ray_t           r12_next, r12_reg;
    logic           v12_reg;

    always_comb
    begin
        r12_next = d2s_reg[NUM2_W-1];
        tm2      = cap_mag(PROD_W'(d2w[NUM2_W].quo[NUM2_W-1:0]));
        tn2      = r12_next.cneg ^ r12_next.tneg;
        if (!r12_next.hit1) begin
            r12_next.tmag = tm2;
            r12_next.tneg = tn2;
            if (!in_range(tn2, tm2, r12_next.tlo, r12_next.thi)) begin
                r12_next.miss = 1'b1;
            end
        end
        if (rad_reg == '0) begin
            r12_next.miss = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        r12_reg <= r12_next;
    end

    // Hit point.
    logic [2:0][PROD_W-1:0]   pt_prod;
    ray_t                     m3_reg [2];
    logic [1:0]               m3v_reg;
    logic [2:0][T_W-1:0]      pm;
    logic signed [WIDE_W-1:0] pt_w [3];
    ray_t                     r15_next, r15_reg;
    logic                     v15_reg;

    for (genvar i = 0; i < 3; i++) begin : g_mul_pt
        rsi_mul u_mul_pt (
            .clk  (clk),
            .x    (MUL_W'(r12_reg.tmag)),
            .y    (MUL_W'(r12_reg.dmag[i])),
            .prod (pt_prod[i])
        );
    end

    always_ff @(posedge clk)
    begin
        m3_reg[0] <= r12_reg;
        m3_reg[1] <= m3_reg[0];
    end

    always_comb
    begin
        r15_next = m3_reg[1];
        for (int i = 0; i < 3; i++) begin
            pm[i] = cap_mag(pt_prod[i] >> FRAC_BITS);
            if (r15_next.tneg ^ r15_next.dneg[i]) begin
                pt_w[i] = WIDE_W'($signed(r15_next.o[i])) - WIDE_W'(pm[i]);
            end
            else begin
                pt_w[i] = WIDE_W'($signed(r15_next.o[i])) + WIDE_W'(pm[i]);
            end
            r15_next.pt[i] = sat_coord(pt_w[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        r15_reg <= r15_next;
    end

    // Normal: offset from the center, then division by the radius.
    logic [2:0][COORD_W:0] diff;
    logic [2:0][COORD_W:0] dmg;
    div_t                  d3_in_next [3];
    div_t                  d3_in_reg [3];
    ray_t                  r16_next, r16_reg;
    logic                  v16_reg;
    div_t                  d3w [3][NUMN_W+1];
    ray_t                  d3s_reg [NUMN_W];
    logic [NUMN_W-1:0]     d3v_reg;

    always_comb
    begin
        r16_next = r15_reg;
        for (int i = 0; i < 3; i++) begin
            diff[i]           = (COORD_W+1)'($signed(r15_reg.pt[i]))
                              - (COORD_W+1)'($signed(ctr_reg[i]));
            r16_next.nneg[i]  = diff[i][COORD_W];
            dmg[i]            = r16_next.nneg[i] ? -diff[i] : diff[i];
            d3_in_next[i]     = '0;
            d3_in_next[i].num = DIV_NUM_W'(NUMN_W'(dmg[i]) << FRAC_BITS)
                                << (DIV_NUM_W - NUMN_W);
            d3_in_next[i].den = DIV_DEN_W'(rad_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++) begin
            d3_in_reg[i] <= d3_in_next[i];
        end
        r16_reg <= r16_next;
    end

    for (genvar i = 0; i < 3; i++) begin : g_div3
        assign d3w[i][0] = d3_in_reg[i];
        for (genvar k = 0; k < NUMN_W; k++) begin : g_cell
            rsi_div_cell u_cell (
                .clk   (clk),
                .d_in  (d3w[i][k]),
                .d_out (d3w[i][k+1])
            );
        end
    end

    always_ff @(posedge clk)
    begin
        d3s_reg[0] <= r16_reg;
        for (int k = 1; k < NUMN_W; k++) begin
            d3s_reg[k] <= d3s_reg[k-1];
        end
    end

    // Result register.
    ray_t                     rf;
    logic signed [WIDE_W-1:0] t_w;
    logic signed [WIDE_W-1:0] n_w [3];
    logic [NUMN_W-1:0]        nm [3];
    logic                     done_reg;
    logic                     hit_reg;
    logic [COORD_W-1:0]       hit_t_reg;
    logic [2:0][COORD_W-1:0]  point_reg, normal_reg;
    logic [COORD_W-1:0]       hit_t_next;
    logic [2:0][COORD_W-1:0]  point_next, normal_next;

    always_comb
    begin
        rf  = d3s_reg[NUMN_W-1];
        t_w = rf.tneg ? -$signed(WIDE_W'(rf.tmag)) : $signed(WIDE_W'(rf.tmag));
        hit_t_next = rf.miss ? '0 : t_w[COORD_W-1:0];
        for (int i = 0; i < 3; i++) begin
            nm[i]  = d3w[i][NUMN_W].quo[NUMN_W-1:0];
            n_w[i] = rf.nneg[i] ? -$signed(WIDE_W'(nm[i])) : $signed(WIDE_W'(nm[i]));
            point_next[i]  = rf.miss ? '0 : rf.pt[i];
            normal_next[i] = rf.miss ? '0 : sat_coord(n_w[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        hit_reg    <= ~rf.miss;
        hit_t_reg  <= hit_t_next;
        point_reg  <= point_next;
        normal_reg <= normal_next;
    end

    // Request valid flags along the pipeline.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            v0_reg   <= 1'b0;
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            m1v_reg  <= '0;
            v6_reg   <= 1'b0;
            sqv_reg  <= '0;
            v7_reg   <= 1'b0;
            d1v_reg  <= '0;
            v8_reg   <= 1'b0;
            m2v_reg  <= '0;
            v11_reg  <= 1'b0;
            d2v_reg  <= '0;
            v12_reg  <= 1'b0;
            m3v_reg  <= '0;
            v15_reg  <= 1'b0;
            v16_reg  <= 1'b0;
            d3v_reg  <= '0;
            done_reg <= 1'b0;
        end
        else begin
            v0_reg   <= start;
            v1_reg   <= v0_reg;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            m1v_reg  <= {m1v_reg[0], v3_reg};
            v6_reg   <= m1v_reg[1];
            sqv_reg  <= {sqv_reg[S_W-2:0], v6_reg};
            v7_reg   <= sqv_reg[S_W-1];
            d1v_reg  <= {d1v_reg[NUM1_W-2:0], v7_reg};
            v8_reg   <= d1v_reg[NUM1_W-1];
            m2v_reg  <= {m2v_reg[0], v8_reg};
            v11_reg  <= m2v_reg[1];
            d2v_reg  <= {d2v_reg[NUM2_W-2:0], v11_reg};
            v12_reg  <= d2v_reg[NUM2_W-1];
            m3v_reg  <= {m3v_reg[0], v12_reg};
            v15_reg  <= m3v_reg[1];
            v16_reg  <= v15_reg;
            d3v_reg  <= {d3v_reg[NUMN_W-2:0], v16_reg};
            done_reg <= d3v_reg[NUMN_W-1];
        end
    end

    assign done     = done_reg;
    assign is_hit   = hit_reg;
    assign hit_t    = hit_t_reg;
    assign point_x  = point_reg[0];
    assign point_y  = point_reg[1];
    assign point_z  = point_reg[2];
    assign normal_x = normal_reg[0];
    assign normal_y = normal_reg[1];
    assign normal_z = normal_reg[2];

endmodule

@@ sv/rsi_mul.sv @@
// Two-stage unsigned multiplier built from four half-width partial products.
// Depends on rsi_pkg for the operand and product widths.
module rsi_mul
    import rsi_pkg::*;
(
    input  logic              clk,
    input  logic [MUL_W-1:0]  x,
    input  logic [MUL_W-1:0]  y,
    output logic [PROD_W-1:0] prod
);

    localparam int HALF = MUL_W / 2;

    logic [MUL_W-1:0]  p00_reg, p01_reg, p10_reg, p11_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [PROD_W-1:0] prod_next;

    always_comb
    begin
        prod_next = PROD_W'(p00_reg)
                  + (PROD_W'(p01_reg) << HALF)
                  + (PROD_W'(p10_reg) << HALF)
                  + (PROD_W'(p11_reg) << MUL_W);
    end

    always_ff @(posedge clk)
    begin
        p00_reg  <= MUL_W'(x[HALF-1:0]) * MUL_W'(y[HALF-1:0]);
        p01_reg  <= MUL_W'(x[HALF-1:0]) * MUL_W'(y[MUL_W-1:HALF]);
        p10_reg  <= MUL_W'(x[MUL_W-1:HALF]) * MUL_W'(y[HALF-1:0]);
        p11_reg  <= MUL_W'(x[MUL_W-1:HALF]) * MUL_W'(y[MUL_W-1:HALF]);
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

@@ sv/rsi_sqrt_cell.sv @@
// One step of the digit-by-digit square root: takes two radicand bits, yields one root bit.
// Depends on rsi_pkg for sqrt_t.
module rsi_sqrt_cell
    import rsi_pkg::*;
(
    input  logic  clk,
    input  sqrt_t d_in,
    output sqrt_t d_out
);

    logic [S_W+2:0] rem_w;
    logic [S_W+2:0] trial;
    logic [S_W+2:0] diff_w;
    logic           ge;
    sqrt_t          cell_next;
    sqrt_t          cell_reg;

    always_comb
    begin
        rem_w  = {d_in.rem, d_in.rad[DIS_W-1 -: 2]};
        trial  = {1'b0, d_in.root, 2'b01};
        diff_w = rem_w - trial;
        ge     = (rem_w >= trial);
        cell_next.rad  = d_in.rad << 2;
        cell_next.root = {d_in.root[S_W-2:0], ge};
        if (ge) begin
            cell_next.rem = diff_w[S_W:0];
        end
        else begin
            cell_next.rem = rem_w[S_W:0];
        end
    end

    always_ff @(posedge clk)
    begin
        cell_reg <= cell_next;
    end

    assign d_out = cell_reg;

endmodule

@@ sv/rsi_div_cell.sv @@
// One step of restoring division: shifts in one numerator bit and yields one quotient bit.
// Depends on rsi_pkg for div_t.
module rsi_div_cell
    import rsi_pkg::*;
(
    input  logic clk,
    input  div_t d_in,
    output div_t d_out
);

    logic [DIV_DEN_W:0] rem_w;
    logic [DIV_DEN_W:0] diff;
    logic               ge;
    div_t               cell_next;
    div_t               cell_reg;

    always_comb
    begin
        rem_w = {d_in.rem, d_in.num[DIV_NUM_W-1]};
        diff  = rem_w - {1'b0, d_in.den};
        ge    = (rem_w >= {1'b0, d_in.den});
        cell_next.num = d_in.num << 1;
        cell_next.den = d_in.den;
        cell_next.quo = {d_in.quo[DIV_NUM_W-2:0], ge};
        cell_next.rem = ge ? diff[DIV_DEN_W-1:0] : rem_w[DIV_DEN_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        cell_reg <= cell_next;
    end

    assign d_out = cell_reg;

endmodule
